// ===== rtl/smbt_pkg.sv =====
// ---------------------------------------------------------------------------
// smbt_pkg : shared types and constants of the scaled GEMM (B transposed)
// Command codes, register indexes, sequencer states and the control struct
// that the sequencer hands to the shared multiply-accumulate unit.
// ---------------------------------------------------------------------------
`default_nettype none

package smbt_pkg;

   // defaults of the top-level parameters
   localparam int DEF_MAX_DIM    = 8;
   localparam int DEF_ELEM_WIDTH = 32;

   // fixed field widths
   localparam int CMD_WIDTH       = 2;
   localparam int IDX_WIDTH       = 3;
   localparam int VALUE_WIDTH     = 32;
   localparam int DIM_WIDTH       = 4;
   localparam int SCALE_WIDTH     = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // arithmetic widths: one 32x32 signed multiplier, Q16.16
   localparam int MUL_WIDTH  = 32;
   localparam int PROD_WIDTH = 2 * MUL_WIDTH;
   localparam int FRAC_BITS  = 16;
   // shifted product plus headroom for up to eight terms
   localparam int ACC_WIDTH  = PROD_WIDTH - FRAC_BITS + 4;

   localparam logic [DIM_WIDTH-1:0]          DIM_RESET   = 4'd8;
   localparam logic signed [SCALE_WIDTH-1:0] SCALE_RESET = 32'sd65536;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NUM_ROWS  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NUM_COLS  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INNER_LEN = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ALPHA     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BETA      = 3'd4;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_LOAD_C = 2'd2,
      CMD_RUN    = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DOT_RD,
      ST_DOT_MUL,
      ST_DOT_ACC,
      ST_SUM,
      ST_MUL_C,
      ST_MUL_BETA,
      ST_FINAL,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      OPS_AB,
      OPS_ALPHA_C,
      OPS_BETA_SUM
   } opsel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic       mul_en;
      opsel_type  opsel;
      acc_op_type acc_op;
      logic       sum_en;
   } mac_ctrl_type;

   typedef struct packed {
      logic [DIM_WIDTH-1:0] num_rows;
      logic [DIM_WIDTH-1:0] num_cols;
      logic [DIM_WIDTH-1:0] inner_len;
   } dims_type;

endpackage

`default_nettype wire

// ===== rtl/scaled_matrix_multiply_bt_unit.sv =====
// ---------------------------------------------------------------------------
// scaled_matrix_multiply_bt_unit : Q16.16 C = alpha*C + beta*A*B^T
// Loads A, B and C elements one per transaction; a run command rewrites
// C for every p, q and streams each new element out in row-major order.
// ---------------------------------------------------------------------------
//
//  channel   handshake           payload
//  --------  ------------------  -------------------------------------------
//  request   start & !busy       req_cmd, req_row_idx, req_col_idx,
//                                req_elem_value
//  response  rsp_strobe (1 cyc)  rsp_out_row, rsp_out_col, rsp_out_value,
//                                rsp_is_last
//  csr       csr_we              csr_index, csr_wdata (write only)
//
// A load transaction leaves busy low, so the next transaction may follow at
// once. A run keeps busy high from the cycle after it is accepted until its
// last element is out: each term is one read, one multiply and one
// accumulate through the single shared multiplier, and each element then
// passes through the sum saturation, alpha and beta products and write-back.
// A run with zero rows or columns gives no results and busy stays low.
// Reset clears the sequencer and the registers; the A, B and C stores are
// not cleared. The receiver cannot stall: each result shows for one cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module scaled_matrix_multiply_bt_unit #(
   parameter int MAX_DIM    = smbt_pkg::DEF_MAX_DIM,
   parameter int ELEM_WIDTH = smbt_pkg::DEF_ELEM_WIDTH
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // request
   input  wire logic                                     start,
   output logic                                          busy,
   input  wire logic [smbt_pkg::CMD_WIDTH-1:0]           req_cmd,
   input  wire logic [smbt_pkg::IDX_WIDTH-1:0]           req_row_idx,
   input  wire logic [smbt_pkg::IDX_WIDTH-1:0]           req_col_idx,
   input  wire logic signed [smbt_pkg::VALUE_WIDTH-1:0]  req_elem_value,
   // response
   output logic                                          rsp_strobe,
   output logic [smbt_pkg::IDX_WIDTH-1:0]                rsp_out_row,
   output logic [smbt_pkg::IDX_WIDTH-1:0]                rsp_out_col,
   output logic signed [smbt_pkg::VALUE_WIDTH-1:0]       rsp_out_value,
   output logic                                          rsp_is_last,
   // configuration
   input  wire logic                                     csr_we,
   input  wire logic [smbt_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [smbt_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);

   import smbt_pkg::*;

   localparam int DEPTH      = MAX_DIM * MAX_DIM;
   localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   // ---------------- configuration registers ----------------
   logic [DIM_WIDTH-1:0]          num_rows_ff, num_rows_in;
   logic [DIM_WIDTH-1:0]          num_cols_ff, num_cols_in;
   logic [DIM_WIDTH-1:0]          inner_len_ff, inner_len_in;
   logic signed [SCALE_WIDTH-1:0] alpha_ff, alpha_in;
   logic signed [SCALE_WIDTH-1:0] beta_ff, beta_in;

   always_comb begin
      num_rows_in  = num_rows_ff;
      num_cols_in  = num_cols_ff;
      inner_len_in = inner_len_ff;
      alpha_in     = alpha_ff;
      beta_in      = beta_ff;
      if (csr_we) begin
         case (csr_index)
            REG_NUM_ROWS:  num_rows_in  = csr_wdata[DIM_WIDTH-1:0];
            REG_NUM_COLS:  num_cols_in  = csr_wdata[DIM_WIDTH-1:0];
            REG_INNER_LEN: inner_len_in = csr_wdata[DIM_WIDTH-1:0];
            REG_ALPHA:     alpha_in     = signed'(csr_wdata[SCALE_WIDTH-1:0]);
            REG_BETA:      beta_in      = signed'(csr_wdata[SCALE_WIDTH-1:0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff  <= DIM_RESET;
         num_cols_ff  <= DIM_RESET;
         inner_len_ff <= DIM_RESET;
         alpha_ff     <= SCALE_RESET;
         beta_ff      <= SCALE_RESET;
      end else begin
         num_rows_ff  <= num_rows_in;
         num_cols_ff  <= num_cols_in;
         inner_len_ff <= inner_len_in;
         alpha_ff     <= alpha_in;
         beta_ff      <= beta_in;
      end
   end

   // sizes above the store dimension act as the store dimension
   dims_type dims;
   assign dims.num_rows  = (num_rows_ff > DIM_WIDTH'(MAX_DIM)) ?
                           DIM_WIDTH'(MAX_DIM) : num_rows_ff;
   assign dims.num_cols  = (num_cols_ff > DIM_WIDTH'(MAX_DIM)) ?
                           DIM_WIDTH'(MAX_DIM) : num_cols_ff;
   assign dims.inner_len = (inner_len_ff > DIM_WIDTH'(MAX_DIM)) ?
                           DIM_WIDTH'(MAX_DIM) : inner_len_ff;

   // ---------------- request decode ----------------
   logic                  accept;
   logic                  run_go;
   logic                  load_ok;
   logic [ADDR_WIDTH-1:0] load_addr;
   logic [ELEM_WIDTH-1:0] load_data;

   assign accept  = start && !busy;
   assign run_go  = accept && (req_cmd == CMD_RUN);
   // loads outside the store are dropped
   assign load_ok = accept && (req_cmd != CMD_RUN)
                    && (DIM_WIDTH'(req_row_idx) < DIM_WIDTH'(MAX_DIM))
                    && (DIM_WIDTH'(req_col_idx) < DIM_WIDTH'(MAX_DIM));
   assign load_addr = ADDR_WIDTH'(req_row_idx) * ADDR_WIDTH'(MAX_DIM)
                      + ADDR_WIDTH'(req_col_idx);
   assign load_data = req_elem_value[ELEM_WIDTH-1:0];

   // ---------------- sequencer ----------------
   mac_ctrl_type         ctrl;
   logic [CNT_WIDTH-1:0] p_idx, q_idx, r_idx;
   logic                 seq_c_wr;

   smbt_seq #(
      .MAX_DIM   (MAX_DIM),
      .CNT_WIDTH (CNT_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .run_go      (run_go),
      .dims        (dims),
      .ctrl        (ctrl),
      .p_idx       (p_idx),
      .q_idx       (q_idx),
      .r_idx       (r_idx),
      .busy        (busy),
      .c_wr        (seq_c_wr),
      .rsp_strobe  (rsp_strobe),
      .rsp_is_last (rsp_is_last)
   );

   // store addresses, row-major with row stride MAX_DIM
   logic [ADDR_WIDTH-1:0] a_rd_addr, b_rd_addr, c_run_addr;
   assign a_rd_addr  = ADDR_WIDTH'(p_idx) * ADDR_WIDTH'(MAX_DIM) + ADDR_WIDTH'(r_idx);
   assign b_rd_addr  = ADDR_WIDTH'(q_idx) * ADDR_WIDTH'(MAX_DIM) + ADDR_WIDTH'(r_idx);
   assign c_run_addr = ADDR_WIDTH'(p_idx) * ADDR_WIDTH'(MAX_DIM) + ADDR_WIDTH'(q_idx);

   // ---------------- stores ----------------
   logic [ELEM_WIDTH-1:0]        a_rd_data, b_rd_data, c_rd_data;
   logic signed [ELEM_WIDTH-1:0] mac_result;
   logic                         c_wr_en;
   logic [ADDR_WIDTH-1:0]        c_wr_addr;
   logic [ELEM_WIDTH-1:0]        c_wr_data;

   // run write-back only happens while busy, loads only while idle
   assign c_wr_en   = seq_c_wr || (load_ok && (req_cmd == CMD_LOAD_C));
   assign c_wr_addr = seq_c_wr ? c_run_addr : load_addr;
   assign c_wr_data = seq_c_wr ? mac_result : load_data;

   smbt_ram #(
      .WIDTH      (ELEM_WIDTH),
      .DEPTH      (DEPTH),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (load_ok && (req_cmd == CMD_LOAD_A)),
      .wr_addr (load_addr),
      .wr_data (load_data),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   smbt_ram #(
      .WIDTH      (ELEM_WIDTH),
      .DEPTH      (DEPTH),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (load_ok && (req_cmd == CMD_LOAD_B)),
      .wr_addr (load_addr),
      .wr_data (load_data),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   smbt_ram #(
      .WIDTH      (ELEM_WIDTH),
      .DEPTH      (DEPTH),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_c_store (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_addr (c_run_addr),
      .rd_data (c_rd_data)
   );

   // ---------------- shared arithmetic ----------------
   smbt_mac #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_mac (
      .clock  (clock),
      .ctrl   (ctrl),
      .a_data (signed'(a_rd_data)),
      .b_data (signed'(b_rd_data)),
      .c_data (signed'(c_rd_data)),
      .alpha  (alpha_ff),
      .beta   (beta_ff),
      .result (mac_result)
   );

   // ---------------- response ----------------
   assign rsp_out_row   = IDX_WIDTH'(p_idx);
   assign rsp_out_col   = IDX_WIDTH'(q_idx);
   assign rsp_out_value = VALUE_WIDTH'(mac_result);

endmodule

`default_nettype wire

// ===== rtl/smbt_ram.sv =====
// ---------------------------------------------------------------------------
// smbt_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module smbt_ram #(
   parameter int WIDTH      = 32,
   parameter int DEPTH      = 64,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/smbt_mac.sv =====
// ---------------------------------------------------------------------------
// smbt_mac : shared multiply / shift / accumulate / saturate unit
// One registered 32x32 signed multiplier, Q16.16 shift, accumulator and
// saturation; also holds the saturated dot product for the beta term.
// ---------------------------------------------------------------------------
`default_nettype none

module smbt_mac #(
   parameter int ELEM_WIDTH = smbt_pkg::DEF_ELEM_WIDTH
) (
   input  wire logic                                      clock,
   input  wire smbt_pkg::mac_ctrl_type                    ctrl,
   input  wire logic signed [ELEM_WIDTH-1:0]              a_data,
   input  wire logic signed [ELEM_WIDTH-1:0]              b_data,
   input  wire logic signed [ELEM_WIDTH-1:0]              c_data,
   input  wire logic signed [smbt_pkg::SCALE_WIDTH-1:0]   alpha,
   input  wire logic signed [smbt_pkg::SCALE_WIDTH-1:0]   beta,
   output logic      signed [ELEM_WIDTH-1:0]              result
);

   import smbt_pkg::*;

   localparam logic signed [ACC_WIDTH-1:0] SAT_HI =
      ACC_WIDTH'((longint'(1) <<< (ELEM_WIDTH - 1)) - longint'(1));
   localparam logic signed [ACC_WIDTH-1:0] SAT_LO = -SAT_HI - ACC_WIDTH'(1);

   logic signed [MUL_WIDTH-1:0]  mul_a;
   logic signed [MUL_WIDTH-1:0]  mul_b;
   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic signed [PROD_WIDTH-1:0] prod_in;
   logic signed [ACC_WIDTH-1:0]  prod_sh;
   logic signed [ACC_WIDTH-1:0]  acc_ff;
   logic signed [ACC_WIDTH-1:0]  acc_in;
   logic signed [ELEM_WIDTH-1:0] sum_ff;
   logic signed [ELEM_WIDTH-1:0] sum_in;
   logic signed [ELEM_WIDTH-1:0] acc_sat;

   // operand select
   always_comb begin
      case (ctrl.opsel)
         OPS_AB: begin
            mul_a = MUL_WIDTH'(a_data);
            mul_b = MUL_WIDTH'(b_data);
         end
         OPS_ALPHA_C: begin
            mul_a = MUL_WIDTH'(alpha);
            mul_b = MUL_WIDTH'(c_data);
         end
         OPS_BETA_SUM: begin
            mul_a = MUL_WIDTH'(beta);
            mul_b = MUL_WIDTH'(sum_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = ctrl.mul_en ? (mul_a * mul_b) : prod_ff;

   // arithmetic shift right by the fraction width
   assign prod_sh = ACC_WIDTH'(signed'(prod_ff[PROD_WIDTH-1:FRAC_BITS]));

   always_comb begin
      case (ctrl.acc_op)
         ACC_HOLD:  acc_in = acc_ff;
         ACC_CLEAR: acc_in = '0;
         ACC_LOAD:  acc_in = prod_sh;
         ACC_ADD:   acc_in = acc_ff + prod_sh;
         default:   acc_in = acc_ff;
      endcase
   end

   always_comb begin
      if (acc_ff > SAT_HI) begin
         acc_sat = SAT_HI[ELEM_WIDTH-1:0];
      end else if (acc_ff < SAT_LO) begin
         acc_sat = SAT_LO[ELEM_WIDTH-1:0];
      end else begin
         acc_sat = acc_ff[ELEM_WIDTH-1:0];
      end
   end

   assign sum_in = ctrl.sum_en ? acc_sat : sum_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      sum_ff  <= sum_in;
   end

   assign result = acc_sat;

endmodule

`default_nettype wire

// ===== rtl/smbt_seq.sv =====
// ---------------------------------------------------------------------------
// smbt_seq : run sequencer
// Walks p, q and r, steps the shared unit through the dot product and the
// alpha/beta scaling, and marks each result element.
// ---------------------------------------------------------------------------
`default_nettype none

module smbt_seq #(
   parameter int MAX_DIM   = smbt_pkg::DEF_MAX_DIM,
   parameter int CNT_WIDTH = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    run_go,
   input  wire smbt_pkg::dims_type      dims,
   output smbt_pkg::mac_ctrl_type       ctrl,
   output logic [CNT_WIDTH-1:0]         p_idx,
   output logic [CNT_WIDTH-1:0]         q_idx,
   output logic [CNT_WIDTH-1:0]         r_idx,
   output logic                         busy,
   output logic                         c_wr,
   output logic                         rsp_strobe,
   output logic                         rsp_is_last
);

   import smbt_pkg::*;

   state_type state_ff, state_in;
   logic [CNT_WIDTH-1:0] p_ff, p_in, q_ff, q_in, r_ff, r_in;
   logic p_last, q_last, r_last, run_ok, skip_dot;

   assign p_last   = (DIM_WIDTH'(p_ff) + DIM_WIDTH'(1)) == dims.num_rows;
   assign q_last   = (DIM_WIDTH'(q_ff) + DIM_WIDTH'(1)) == dims.num_cols;
   assign r_last   = (DIM_WIDTH'(r_ff) + DIM_WIDTH'(1)) == dims.inner_len;
   assign run_ok   = run_go && (dims.num_rows != '0) && (dims.num_cols != '0);
   assign skip_dot = (dims.inner_len == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (run_ok) begin
               state_in = skip_dot ? ST_SUM : ST_DOT_RD;
            end
         end
         ST_DOT_RD:   state_in = ST_DOT_MUL;
         ST_DOT_MUL:  state_in = ST_DOT_ACC;
         ST_DOT_ACC:  state_in = r_last ? ST_SUM : ST_DOT_RD;
         ST_SUM:      state_in = ST_MUL_C;
         ST_MUL_C:    state_in = ST_MUL_BETA;
         ST_MUL_BETA: state_in = ST_FINAL;
         ST_FINAL:    state_in = ST_OUT;
         ST_OUT: begin
            if (p_last && q_last) begin
               state_in = ST_IDLE;
            end else begin
               state_in = skip_dot ? ST_SUM : ST_DOT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl.mul_en = 1'b0;
      ctrl.opsel  = OPS_AB;
      ctrl.acc_op = ACC_HOLD;
      ctrl.sum_en = 1'b0;
      c_wr        = 1'b0;
      rsp_strobe  = 1'b0;
      busy        = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            ctrl.acc_op = ACC_CLEAR;
         end
         ST_DOT_RD: begin
         end
         ST_DOT_MUL: begin
            ctrl.mul_en = 1'b1;
         end
         ST_DOT_ACC: begin
            ctrl.acc_op = ACC_ADD;
         end
         ST_SUM: begin
            ctrl.sum_en = 1'b1;
         end
         ST_MUL_C: begin
            ctrl.mul_en = 1'b1;
            ctrl.opsel  = OPS_ALPHA_C;
         end
         ST_MUL_BETA: begin
            ctrl.mul_en = 1'b1;
            ctrl.opsel  = OPS_BETA_SUM;
            ctrl.acc_op = ACC_LOAD;
         end
         ST_FINAL: begin
            ctrl.acc_op = ACC_ADD;
         end
         ST_OUT: begin
            ctrl.acc_op = ACC_CLEAR;
            c_wr        = 1'b1;
            rsp_strobe  = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   assign rsp_is_last = rsp_strobe && p_last && q_last;

   // index counters
   always_comb begin
      p_in = p_ff;
      q_in = q_ff;
      r_in = r_ff;
      case (state_ff)
         ST_IDLE: begin
            if (run_go) begin
               p_in = '0;
               q_in = '0;
               r_in = '0;
            end
         end
         ST_DOT_ACC: begin
            r_in = r_last ? '0 : r_ff + CNT_WIDTH'(1);
         end
         ST_OUT: begin
            r_in = '0;
            if (q_last) begin
               q_in = '0;
               p_in = p_ff + CNT_WIDTH'(1);
            end else begin
               q_in = q_ff + CNT_WIDTH'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         p_ff     <= '0;
         q_ff     <= '0;
         r_ff     <= '0;
      end else begin
         state_ff <= state_in;
         p_ff     <= p_in;
         q_ff     <= q_in;
         r_ff     <= r_in;
      end
   end

   assign p_idx = p_ff;
   assign q_idx = q_ff;
   assign r_idx = r_ff;

endmodule

`default_nettype wire

// ===== rtl/smbt_checker.sv =====
// ---------------------------------------------------------------------------
// smbt_checker : port-level checks of the scaled GEMM unit
// Watches the request and response ports over time; bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module smbt_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic [smbt_pkg::CMD_WIDTH-1:0] req_cmd,
   input wire logic                           rsp_strobe,
   input wire logic                           rsp_is_last
);

   import smbt_pkg::*;

   // results only come out of a run in progress
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while not busy");

   // a load transaction never makes the block busy
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd != CMD_RUN)) |=> !busy)
      else $error("load transaction raised busy");

   // each element passes SUM, MUL_C, MUL_BETA and FINAL before its strobe, so strobes never sit back to back
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result strobes");

   // the last element ends the run
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_is_last) |=> !busy)
      else $error("busy after last result");

   // a run only finishes through its last element
   a_fall_after_last: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> $past(rsp_strobe && rsp_is_last))
      else $error("run ended without a last result");

endmodule

bind scaled_matrix_multiply_bt_unit smbt_checker u_smbt_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top : self-checking bench for the scaled GEMM unit (B transposed)
// Loads A, B and C elements, programs sizes and Q16.16 scales between
// phases, issues run transactions and checks every streamed C element
// against an in-bench Q16.16 predictor of C = alpha*C + beta*A*B^T.
// ---------------------------------------------------------------------------
module tb_top;
   import smbt_pkg::*;

   localparam int DIM          = DEF_MAX_DIM;
   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 12;
   localparam int ITEM_TARGET  = 380;
   // a load never raises busy and the sequencer drops busy right after the
   // last element, so SETTLE_CYCLES covers whatever is still in flight
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 32;
   localparam int MAX_REPORTS   = 10;
   // worst case: every item a full 8x8x8 run, with margin to spare
   localparam int TIMEOUT_NS    = 100_000_000;

   localparam logic [VALUE_WIDTH-1:0] Q_ONE     = 32'h0001_0000;
   localparam logic [VALUE_WIDTH-1:0] Q_MAX_VAL = 32'h7FFF_FFFF;
   localparam logic [VALUE_WIDTH-1:0] Q_MIN_VAL = 32'h8000_0000;
   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -SAT_HI - 1;

   // one streamed C element
   typedef struct packed {
      logic [IDX_WIDTH-1:0]          row;
      logic [IDX_WIDTH-1:0]          col;
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          last;
   } c_elem_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   cmd_type                       req_cmd;
   logic [IDX_WIDTH-1:0]          req_row_idx;
   logic [IDX_WIDTH-1:0]          req_col_idx;
   logic signed [VALUE_WIDTH-1:0] req_elem_value;
   logic                          rsp_strobe;
   logic [IDX_WIDTH-1:0]          rsp_out_row;
   logic [IDX_WIDTH-1:0]          rsp_out_col;
   logic signed [VALUE_WIDTH-1:0] rsp_out_value;
   logic                          rsp_is_last;
   logic                          csr_we;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index;
   logic [CSR_DATA_WIDTH-1:0]     csr_wdata;

   // predictor state: the three stores, which entries were loaded, and
   // the register file as the block should hold it
   logic signed [VALUE_WIDTH-1:0] a_mat [DIM*DIM];
   logic signed [VALUE_WIDTH-1:0] b_mat [DIM*DIM];
   logic signed [VALUE_WIDTH-1:0] c_mat [DIM*DIM];
   bit                            a_set [DIM*DIM];
   bit                            b_set [DIM*DIM];
   bit                            c_set [DIM*DIM];
   logic [DIM_WIDTH-1:0]          rows_cfg;
   logic [DIM_WIDTH-1:0]          cols_cfg;
   logic [DIM_WIDTH-1:0]          inner_cfg;
   logic signed [SCALE_WIDTH-1:0] alpha_cfg;
   logic signed [SCALE_WIDTH-1:0] beta_cfg;

   c_elem_type c_elems_due [$];   // C elements predicted, oldest first
   int         fail_count;
   int         items_sent;
   bit         back_to_back;      // phase with no request-side gaps

   scaled_matrix_multiply_bt_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_row_idx    (req_row_idx),
      .req_col_idx    (req_col_idx),
      .req_elem_value (req_elem_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_value  (rsp_out_value),
      .rsp_is_last    (rsp_is_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   initial begin
      #TIMEOUT_NS;
      $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Q16.16 arithmetic of the predictor
   // ------------------------------------------------------------------
   function automatic int eff_dim(logic [DIM_WIDTH-1:0] d);
      return (d > DIM) ? DIM : int'(d);
   endfunction

   function automatic logic signed [VALUE_WIDTH-1:0] clip_q16(longint v);
      if (v > SAT_HI) return Q_MAX_VAL;
      if (v < SAT_LO) return Q_MIN_VAL;
      return v[VALUE_WIDTH-1:0];
   endfunction

   // Updates the stores for a load, or walks the whole run and queues every
   // new C element. Products are floored by the >>> on a signed longint.
   task automatic apply_transaction(cmd_type cmd, logic [IDX_WIDTH-1:0] row,
                                    logic [IDX_WIDTH-1:0] col,
                                    logic signed [VALUE_WIDTH-1:0] value);
      int         rows, cols, depth, p, q, r, slot;
      longint     dot, mix;
      c_elem_type elem;
      slot = int'(row) * DIM + int'(col);
      case (cmd)
         CMD_LOAD_A: begin
            a_mat[slot] = value;
            a_set[slot] = 1'b1;
         end
         CMD_LOAD_B: begin
            b_mat[slot] = value;
            b_set[slot] = 1'b1;
         end
         CMD_LOAD_C: begin
            c_mat[slot] = value;
            c_set[slot] = 1'b1;
         end
         default: begin
            rows  = eff_dim(rows_cfg);
            cols  = eff_dim(cols_cfg);
            depth = eff_dim(inner_cfg);
            for (p = 0; p < rows; p++) begin
               for (q = 0; q < cols; q++) begin
                  dot = 0;
                  for (r = 0; r < depth; r++)
                     dot += (longint'(a_mat[p*DIM+r]) * longint'(b_mat[q*DIM+r]))
                            >>> FRAC_BITS;
                  dot = clip_q16(dot);
                  slot = p * DIM + q;
                  mix = ((longint'(alpha_cfg) * longint'(c_mat[slot])) >>> FRAC_BITS)
                      + ((longint'(beta_cfg) * dot) >>> FRAC_BITS);
                  c_mat[slot] = clip_q16(mix);
                  elem.row   = IDX_WIDTH'(p);
                  elem.col   = IDX_WIDTH'(q);
                  elem.value = c_mat[slot];
                  elem.last  = (p == rows - 1) && (q == cols - 1);
                  c_elems_due.push_back(elem);
               end
            end
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // random picks
   // ------------------------------------------------------------------
   function automatic int next_gap();
      return back_to_back ? 0 : int'($urandom_range(0, 19));
   endfunction

   // mostly small sizes; zero, full and above-full sizes now and then
   function automatic logic [DIM_WIDTH-1:0] pick_dim();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 2)  return '0;
      if (roll < 15) return DIM_WIDTH'($urandom_range(1, 3));
      if (roll < 18) return DIM_WIDTH'($urandom_range(4, DIM));
      return DIM_WIDTH'($urandom_range(DIM + 1, 15));
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] pick_elem_value();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom();
         2: begin
            case ($urandom_range(0, 4))
               0:       return Q_MAX_VAL;
               1:       return Q_MIN_VAL;
               2:       return '0;
               3:       return '1;
               default: return 32'd1;
            endcase
         end
         3, 4:    return (32'($urandom_range(0, 32)) - 32'd16) << FRAC_BITS;
         default: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);  // +-8.0
      endcase
   endfunction

   function automatic logic [SCALE_WIDTH-1:0] pick_scale();
      case ($urandom_range(0, 9))
         0, 1, 2: return Q_ONE;
         3:       return $urandom();
         4: begin
            case ($urandom_range(0, 2))
               0:       return Q_MAX_VAL;
               1:       return Q_MIN_VAL;
               default: return '0;
            endcase
         end
         default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);  // +-4.0
      endcase
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   // Called on a rising-edge step. start stays high after acceptance so a
   // zero-gap follower keeps it up; a later gap or settle_block drops it.
   task automatic send_transaction(cmd_type cmd, logic [IDX_WIDTH-1:0] row,
                                   logic [IDX_WIDTH-1:0] col,
                                   logic [VALUE_WIDTH-1:0] value, int gap);
      bit accepted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_cmd        <= cmd;
      req_row_idx    <= row;
      req_col_idx    <= col;
      req_elem_value <= value;
      // busy is sampled mid-cycle, where it holds the value of the next edge
      do begin
         @(negedge clock);
         accepted = !busy;
         @(posedge clock);
      end while (!accepted);
      apply_transaction(cmd, row, col, value);
      items_sent++;
   endtask

   // Idles the request port and waits for the block to drain.
   task automatic settle_block();
      bit quiet;
      start <= 1'b0;
      do begin
         @(negedge clock);
         quiet = (c_elems_due.size() == 0) && !busy;
         @(posedge clock);
      end while (!quiet);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_WIDTH-1:0] index,
                            logic [CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         REG_NUM_ROWS:  rows_cfg  = data[DIM_WIDTH-1:0];
         REG_NUM_COLS:  cols_cfg  = data[DIM_WIDTH-1:0];
         REG_INNER_LEN: inner_cfg = data[DIM_WIDTH-1:0];
         REG_ALPHA:     alpha_cfg = data;
         REG_BETA:      beta_cfg  = data;
         default: ;
      endcase
   endtask

   // Size registers get junk above their four bits; now and then an
   // unmapped index is hit too, which must change nothing.
   task automatic program_csrs(logic [DIM_WIDTH-1:0] nr, logic [DIM_WIDTH-1:0] nc,
                               logic [DIM_WIDTH-1:0] nk,
                               logic [SCALE_WIDTH-1:0] alpha_val,
                               logic [SCALE_WIDTH-1:0] beta_val);
      csr_write(REG_NUM_ROWS,  {28'($urandom()), nr});
      csr_write(REG_NUM_COLS,  {28'($urandom()), nc});
      csr_write(REG_INNER_LEN, {28'($urandom()), nk});
      csr_write(REG_ALPHA, alpha_val);
      csr_write(REG_BETA,  beta_val);
      if ($urandom_range(0, 3) == 0)
         csr_write(REG_BETA + CSR_INDEX_WIDTH'($urandom_range(1, 3)), $urandom());
      csr_we <= 1'b0;
   endtask

   // Loads every entry that a run with these sizes reads and that was never
   // written, so no run touches an undefined store location.
   task automatic fill_missing(logic [DIM_WIDTH-1:0] nr, logic [DIM_WIDTH-1:0] nc,
                               logic [DIM_WIDTH-1:0] nk);
      int rows, cols, depth, p, q, r;
      rows  = eff_dim(nr);
      cols  = eff_dim(nc);
      depth = eff_dim(nk);
      for (p = 0; p < rows; p++)
         for (r = 0; r < depth; r++)
            if (!a_set[p*DIM+r])
               send_transaction(CMD_LOAD_A, IDX_WIDTH'(p), IDX_WIDTH'(r),
                                pick_elem_value(), next_gap());
      for (q = 0; q < cols; q++)
         for (r = 0; r < depth; r++)
            if (!b_set[q*DIM+r])
               send_transaction(CMD_LOAD_B, IDX_WIDTH'(q), IDX_WIDTH'(r),
                                pick_elem_value(), next_gap());
      for (p = 0; p < rows; p++)
         for (q = 0; q < cols; q++)
            if (!c_set[p*DIM+q])
               send_transaction(CMD_LOAD_C, IDX_WIDTH'(p), IDX_WIDTH'(q),
                                pick_elem_value(), next_gap());
   endtask

   // ------------------------------------------------------------------
   // result side: each strobe is one C element, matched in order
   // ------------------------------------------------------------------
   task automatic note_failure(string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%0t ns mismatch: %s", $time, what);
   endtask

   // sampled mid-cycle, well clear of the edge that updates the outputs
   always @(negedge clock) begin : result_check
      c_elem_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (c_elems_due.size() == 0) begin
            note_failure($sformatf("C element with none due: row %0d col %0d value %0d",
                                   rsp_out_row, rsp_out_col, rsp_out_value));
         end else begin
            want = c_elems_due.pop_front();
            if (rsp_out_row !== want.row || rsp_out_col !== want.col ||
                rsp_out_value !== want.value || rsp_is_last !== want.last)
               note_failure($sformatf(
                  "expected row %0d col %0d value %0d last %0b, got %0d %0d %0d %0b",
                  want.row, want.col, want.value, want.last,
                  rsp_out_row, rsp_out_col, rsp_out_value, rsp_is_last));
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   // 1x1x1: 1.0*1.0 + 1.0*(2.0*3.0) = 7.0, covers every load and a run
   task automatic test_single_element();
      settle_block();
      program_csrs(4'd1, 4'd1, 4'd1, Q_ONE, Q_ONE);
      send_transaction(CMD_LOAD_A, 3'd0, 3'd0, 32'h0002_0000, next_gap());
      send_transaction(CMD_LOAD_B, 3'd0, 3'd0, 32'h0003_0000, next_gap());
      send_transaction(CMD_LOAD_C, 3'd0, 3'd0, Q_ONE, next_gap());
      send_transaction(CMD_RUN, 3'($urandom()), 3'($urandom()), $urandom(), next_gap());
   endtask

   // second run must start from the written-back C
   task automatic test_rerun_feedback();
      settle_block();
      send_transaction(CMD_RUN, 3'($urandom()), 3'($urandom()), $urandom(), 0);
   endtask

   // zero rows, then zero columns: no C elements, busy stays low
   task automatic test_empty_runs();
      settle_block();
      program_csrs(4'd0, 4'd1, 4'd1, Q_ONE, Q_ONE);
      send_transaction(CMD_RUN, 3'd0, 3'd0, '0, next_gap());
      settle_block();
      program_csrs(4'd1, 4'd0, 4'd1, Q_ONE, Q_ONE);
      send_transaction(CMD_RUN, 3'd7, 3'd7, '1, next_gap());
   endtask

   // no inner terms: result is alpha*C alone, alpha = -1.5
   task automatic test_zero_inner();
      settle_block();
      program_csrs(4'd1, 4'd1, 4'd0, 32'hFFFE_8000, Q_ONE);
      send_transaction(CMD_RUN, 3'd0, 3'd0, '0, next_gap());
   endtask

   // saturation of the dot product and of the final value, then the
   // floor on a negative product: -1 lsb * 1 lsb must give -1, not 0
   task automatic test_saturation_rounding();
      settle_block();
      program_csrs(4'd1, 4'd1, 4'd1, Q_MAX_VAL, Q_MIN_VAL);
      send_transaction(CMD_LOAD_A, 3'd0, 3'd0, Q_MAX_VAL, next_gap());
      send_transaction(CMD_LOAD_B, 3'd0, 3'd0, Q_MAX_VAL, next_gap());
      send_transaction(CMD_LOAD_C, 3'd0, 3'd0, Q_MIN_VAL, next_gap());
      send_transaction(CMD_RUN, 3'd0, 3'd0, '0, next_gap());
      settle_block();
      program_csrs(4'd1, 4'd1, 4'd1, Q_ONE, Q_ONE);
      send_transaction(CMD_LOAD_A, 3'd0, 3'd0, '1, next_gap());
      send_transaction(CMD_LOAD_B, 3'd0, 3'd0, 32'd1, next_gap());
      send_transaction(CMD_LOAD_C, 3'd0, 3'd0, '0, next_gap());
      send_transaction(CMD_RUN, 3'd0, 3'd0, '0, next_gap());
   endtask

   // 2x2x2 back to back: row-major order and the last flag
   task automatic test_row_major_order();
      settle_block();
      back_to_back = 1'b1;
      program_csrs(4'd2, 4'd2, 4'd2, 32'hFFFF_8000, 32'h0001_4000);
      fill_missing(4'd2, 4'd2, 4'd2);
      send_transaction(CMD_RUN, 3'd5, 3'd2, $urandom(), next_gap());
      back_to_back = 1'b0;
   endtask

   // Phases of random sizes and scales. The first three force sizes above
   // the store size on each register. Each phase loads random elements,
   // tops up what the run will read, then runs; one to three times.
   task automatic test_random_traffic();
      int                   phase_no, run_count, load_count;
      logic [DIM_WIDTH-1:0] nr, nc, nk;
      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase_no)
            0:       {nr, nc, nk} = {4'd15, 4'd1, 4'd1};
            1:       {nr, nc, nk} = {4'd1, 4'd9, 4'd1};
            2:       {nr, nc, nk} = {4'd1, 4'd1, 4'd15};
            default: {nr, nc, nk} = {pick_dim(), pick_dim(), pick_dim()};
         endcase
         settle_block();
         back_to_back = ($urandom_range(0, 3) == 0);
         program_csrs(nr, nc, nk, pick_scale(), pick_scale());
         run_count = $urandom_range(1, 3);
         repeat (run_count) begin
            load_count = $urandom_range(0, 10);
            repeat (load_count)
               send_transaction(cmd_type'($urandom_range(CMD_LOAD_A, CMD_LOAD_C)),
                                3'($urandom()), 3'($urandom()),
                                pick_elem_value(), next_gap());
            fill_missing(nr, nc, nk);
            send_transaction(CMD_RUN, 3'($urandom()), 3'($urandom()), $urandom(),
                             next_gap());
         end
         phase_no++;
      end
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_cmd        = CMD_LOAD_A;
      req_row_idx    = '0;
      req_col_idx    = '0;
      req_elem_value = '0;
      csr_we         = 1'b0;
      csr_index      = REG_NUM_ROWS;
      csr_wdata      = '0;
      back_to_back   = 1'b0;
      fail_count     = 0;
      items_sent     = 0;
      rows_cfg       = DIM_RESET;
      cols_cfg       = DIM_RESET;
      inner_cfg      = DIM_RESET;
      alpha_cfg      = SCALE_RESET;
      beta_cfg       = SCALE_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_single_element();
      test_rerun_feedback();
      test_empty_runs();
      test_zero_inner();
      test_saturation_rounding();
      test_row_major_order();
      test_random_traffic();

      // drain, then linger so a stray extra element would still be seen
      settle_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (c_elems_due.size() != 0)
         note_failure($sformatf("%0d C elements never arrived", c_elems_due.size()));
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
